[rtl/core/tmcw_pkg.sv]
package tmcw_pkg;

  localparam int DEF_MAX_COLUMNS = 80;
  localparam int DEF_SCREEN_ROWS = 25;

  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int CADDR_W  = 11;
  localparam int WORD_W   = 16;
  localparam int COLOR_W  = 4;
  localparam int KIND_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int PROD_W   = COL_W + ROW_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FG      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BG      = 2'd3;

  localparam logic [COL_W-1:0]   RST_COLUMNS = 7'd80;
  localparam logic [ROW_W-1:0]   RST_ROWS    = 5'd25;
  localparam logic [COLOR_W-1:0] RST_FG      = 4'hF;
  localparam logic [COLOR_W-1:0] RST_BG      = 4'h0;

  localparam logic [CHAR_W-1:0] CH_BS        = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI  = 8'h7F;
  localparam logic [CHAR_W-1:0] TAB_STEP     = 8'd8;

endpackage

[rtl/core/tmcw_mul_unit.sv]
module tmcw_mul_unit
  import tmcw_pkg::*;
(
  input  logic              clk,
  input  logic [ROW_W-1:0]  mul_a,
  input  logic [COL_W-1:0]  mul_b,
  output logic [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

endmodule

[rtl/core/tmcw_screen_ram.sv]
module tmcw_screen_ram
  import tmcw_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_COLUMNS * DEF_SCREEN_ROWS,
  parameter int ADDR_W = $clog2(DEPTH)
)(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WORD_W-1:0] rdata_r
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

[rtl/core/text_mode_console_writer.sv]
// character-cell text console with its own screen store
// input beat: start high while busy is low; kind selects put character,
// set cursor, clear screen or read cell, the other fields go with it
// result beat: out_valid is high for exactly one cycle with the cursor,
// its linear address, the cell word (reads only) and the scroll flag;
// the receiver cannot stall, so a result is never held back
// busy stays high from the accepted beat until the result strobe; a new
// beat may be started in the cycle the strobe shows
// a put multiplies row by columns, writes the cell and, if it scrolls,
// copies each cell below the top row up a row and blanks the last row;
// clear writes every cell; a read is bounded by rows times columns;
// the single write port and shared multiplier set these steps; the user
// makes configuration writes, unchecked, while idle; they act at once
// reset: control and configuration registers reset, then a pass writes
// zero to all MAX_COLUMNS*SCREEN_ROWS cells, one a cycle, with busy high
module text_mode_console_writer
  import tmcw_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic [COL_W-1:0]      in_new_column,
  input  logic [ROW_W-1:0]      in_new_row,
  input  logic [CADDR_W-1:0]    in_cell_address,
  output logic                  out_valid,
  output logic [COL_W-1:0]      out_cursor_column,
  output logic [ROW_W-1:0]      out_cursor_row,
  output logic [CADDR_W-1:0]    out_cursor_linear,
  output logic [WORD_W-1:0]     out_cell_word,
  output logic                  out_scrolled,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int STORE  = MAX_COLUMNS * SCREEN_ROWS;
  localparam int AW     = $clog2(STORE);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_PMUL = 4'd2;
  localparam logic [3:0] S_PUT  = 4'd3;
  localparam logic [3:0] S_SMUL = 4'd4;
  localparam logic [3:0] S_SRD  = 4'd5;
  localparam logic [3:0] S_SWR  = 4'd6;
  localparam logic [3:0] S_FILL = 4'd7;
  localparam logic [3:0] S_CLR  = 4'd8;
  localparam logic [3:0] S_RDM  = 4'd9;
  localparam logic [3:0] S_RD   = 4'd10;
  localparam logic [3:0] S_RDW  = 4'd11;
  localparam logic [3:0] S_LIN  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [COL_W-1:0]   cols_cfg_r;
  logic [ROW_W-1:0]   rows_cfg_r;
  logic [COLOR_W-1:0] fg_r;
  logic [COLOR_W-1:0] bg_r;

  logic [3:0]         state_r, state_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [AW-1:0]      dst_r, dst_nxt;
  logic [COL_W-1:0]   fill_cnt_r, fill_cnt_nxt;
  logic [CHAR_W-1:0]  ch_r, ch_nxt;
  logic [CADDR_W-1:0] addr_r, addr_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic [WORD_W-1:0]  word_r, word_nxt;
  logic               scr_r, scr_nxt;

  logic               out_valid_r;
  logic [COL_W-1:0]   out_col_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [CADDR_W-1:0] out_lin_r;
  logic [WORD_W-1:0]  out_word_r;
  logic               out_scr_r;

  logic [COL_W-1:0]   cols;
  logic [ROW_W-1:0]   rows;
  logic [COL_W-1:0]   col_c;
  logic [ROW_W-1:0]   row_c;
  logic [7:0]         attr;
  logic [WORD_W-1:0]  blank;

  logic [ROW_W-1:0]   mul_a;
  logic [PROD_W-1:0]  prod_r;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [WORD_W-1:0]  wdata;
  logic [AW-1:0]      raddr;
  logic [WORD_W-1:0]  rdata_r;

  logic [PROD_W:0]    put_idx;
  logic [7:0]         nc;
  logic [ROW_W:0]     nr;

  // effective geometry
  always_comb begin
    if (cols_cfg_r == '0) begin
      cols = COL_W'(1);
    end else if (cols_cfg_r > MAX_COLUMNS) begin
      cols = COL_W'(MAX_COLUMNS);
    end else begin
      cols = cols_cfg_r;
    end
    if (rows_cfg_r == '0) begin
      rows = ROW_W'(1);
    end else if (rows_cfg_r > SCREEN_ROWS) begin
      rows = ROW_W'(SCREEN_ROWS);
    end else begin
      rows = rows_cfg_r;
    end
    col_c = (col_r >= cols) ? cols - COL_W'(1) : col_r;
    row_c = (row_r >= rows) ? rows - ROW_W'(1) : row_r;
  end

  assign attr  = {bg_r, fg_r};
  assign blank = {attr, CH_BLANK};
  assign mul_a = (state_r == S_RDM) ? rows : row_r;
  assign put_idx = (PROD_W + 1)'(prod_r) + (PROD_W + 1)'(col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= RST_COLUMNS;
      rows_cfg_r <= RST_ROWS;
      fg_r       <= RST_FG;
      bg_r       <= RST_BG;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLUMNS: cols_cfg_r <= cfg_wdata;
        CFG_ROWS:    rows_cfg_r <= cfg_wdata[ROW_W-1:0];
        CFG_FG:      fg_r       <= cfg_wdata[COLOR_W-1:0];
        CFG_BG:      bg_r       <= cfg_wdata[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    dst_nxt      = dst_r;
    fill_cnt_nxt = fill_cnt_r;
    ch_nxt       = ch_r;
    addr_nxt     = addr_r;
    rd_ok_nxt    = rd_ok_r;
    word_nxt     = word_r;
    scr_nxt      = scr_r;
    we           = 1'b0;
    waddr        = dst_r;
    wdata        = blank;
    raddr        = dst_r;
    nc           = {1'b0, col_r};
    nr           = {1'b0, row_r};
    case (state_r)
      S_IDLE: begin
        col_nxt = col_c;
        row_nxt = row_c;
        if (start) begin
          scr_nxt  = 1'b0;
          word_nxt = '0;
          ch_nxt   = in_char_code;
          addr_nxt = in_cell_address;
          dst_nxt  = '0;
          case (in_kind)
            KIND_PUT:   state_nxt = S_PMUL;
            KIND_SET: begin
              col_nxt   = (in_new_column >= cols) ? cols - COL_W'(1) : in_new_column;
              row_nxt   = (in_new_row >= rows) ? rows - ROW_W'(1) : in_new_row;
              state_nxt = S_LIN;
            end
            KIND_CLEAR: state_nxt = S_CLR;
            default:    state_nxt = S_RDM;
          endcase
        end
      end
      S_INIT: begin
        we      = 1'b1;
        wdata   = '0;
        dst_nxt = dst_r + AW'(1);
        if (dst_r == AW'(STORE - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_PMUL: state_nxt = S_PUT;
      S_PUT: begin
        case (ch_r)
          CH_BS:  nc = (col_r != '0) ? {1'b0, col_r} - 8'd1 : {1'b0, col_r};
          CH_TAB: nc = ({1'b0, col_r} + TAB_STEP) & ~(TAB_STEP - 8'd1);
          CH_CR:  nc = '0;
          CH_LF: begin
            nc = '0;
            nr = {1'b0, row_r} + (ROW_W + 1)'(1);
          end
          default: begin
            if (ch_r inside {[CH_PRINT_LO:CH_PRINT_HI]}) begin
              we    = (put_idx < STORE);
              waddr = AW'(put_idx);
              wdata = {attr, ch_r};
              nc    = {1'b0, col_r} + 8'd1;
            end
          end
        endcase
        if (nc >= {1'b0, cols}) begin
          nc = '0;
          nr = nr + (ROW_W + 1)'(1);
        end
        col_nxt = nc[COL_W-1:0];
        dst_nxt = '0;
        if (nr >= {1'b0, rows}) begin
          row_nxt   = rows - ROW_W'(1);
          state_nxt = S_SMUL;
        end else begin
          row_nxt   = nr[ROW_W-1:0];
          state_nxt = S_LIN;
        end
      end
      S_SMUL: state_nxt = S_SRD;
      S_SRD: begin
        raddr = AW'(dst_r + cols);
        if (dst_r < prod_r) begin
          state_nxt = S_SWR;
        end else begin
          fill_cnt_nxt = '0;
          state_nxt    = S_FILL;
        end
      end
      S_SWR: begin
        we        = 1'b1;
        wdata     = rdata_r;
        dst_nxt   = dst_r + AW'(1);
        state_nxt = S_SRD;
      end
      S_FILL: begin
        we           = 1'b1;
        dst_nxt      = dst_r + AW'(1);
        fill_cnt_nxt = fill_cnt_r + COL_W'(1);
        if (fill_cnt_r == cols - COL_W'(1)) begin
          scr_nxt   = 1'b1;
          state_nxt = S_LIN;
        end
      end
      S_CLR: begin
        we      = 1'b1;
        dst_nxt = dst_r + AW'(1);
        if (dst_r == AW'(STORE - 1)) begin
          col_nxt   = '0;
          row_nxt   = '0;
          state_nxt = S_LIN;
        end
      end
      S_RDM: state_nxt = S_RD;
      S_RD: begin
        raddr     = AW'(addr_r);
        rd_ok_nxt = (addr_r < prod_r) && (addr_r < STORE);
        state_nxt = S_RDW;
      end
      S_RDW: begin
        word_nxt  = rd_ok_r ? rdata_r : '0;
        state_nxt = S_LIN;
      end
      S_LIN:   state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      col_r       <= '0;
      row_r       <= '0;
      dst_r       <= '0;
      fill_cnt_r  <= '0;
      rd_ok_r     <= 1'b0;
      scr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      dst_r       <= dst_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      rd_ok_r     <= rd_ok_nxt;
      scr_r       <= scr_nxt;
      out_valid_r <= (state_r == S_OUT);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ch_r   <= ch_nxt;
    addr_r <= addr_nxt;
    word_r <= word_nxt;
    if (state_r == S_OUT) begin
      out_col_r  <= col_r;
      out_row_r  <= row_r;
      out_lin_r  <= CADDR_W'((PROD_W + 1)'(prod_r) + (PROD_W + 1)'(col_r));
      out_word_r <= word_r;
      out_scr_r  <= scr_r;
    end
  end

  tmcw_mul_unit u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (cols),
    .prod_r (prod_r)
  );

  tmcw_screen_ram #(
    .DEPTH  (STORE),
    .ADDR_W (AW)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata_r (rdata_r)
  );

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_cursor_column = out_col_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_linear = out_lin_r;
  assign out_cell_word     = out_word_r;
  assign out_scrolled      = out_scr_r;

endmodule
